// ----- sv/mat_pkg.sv -----
// Shared types, constants and microprogram for the Metropolis acceptance test.
// Holds payload structs, control word layout, the microcode table and the reciprocal table.
// No dependencies.
package mat_pkg;

    // Payload widths
    localparam int ENERGY_WIDTH = 32;
    localparam int DICE_BITS    = 16;
    localparam int COUNT_W      = 17;
    localparam int ITEMP_W      = 32;
    localparam int ATOMS_W      = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    // Datapath widths
    localparam int MUL_A_W   = 37;
    localparam int MUL_B_W   = 36;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int T_W       = 33;
    localparam int K_W       = 4;
    localparam int SHIFT_W   = 6;

    // Request codes
    localparam logic REQ_TRIAL   = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INV_TEMP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ATOM_COUNT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [ITEMP_W-1:0] INV_TEMP_RST   = 32'd61422;
    localparam logic [ATOMS_W-1:0] ATOM_COUNT_RST = 16'd64;

    // Fixed-point constants
    localparam logic [MUL_B_W-1:0] LOG2E_Q24  = 36'd24204406;
    localparam logic [MUL_B_W-1:0] LN2_Q32    = 36'd2977044472;
    localparam logic [T_W-1:0]     ONE_Q32    = 33'h1_0000_0000;
    localparam logic [63:0]        X_LIMIT    = 64'd23 << 40;
    localparam logic [K_W-1:0]     HORNER_TOP = 4'd9;

    // Input and result beats
    typedef struct packed {
        logic                           req_type;
        logic signed [ENERGY_WIDTH-1:0] old_energy;
        logic signed [ENERGY_WIDTH-1:0] new_energy;
        logic [DICE_BITS-1:0]           dice;
    } mat_in_t;

    typedef struct packed {
        logic                           accepted;
        logic signed [ENERGY_WIDTH-1:0] current_energy;
        logic                           sweep_done;
    } mat_out_t;

    // Microprogram layout
    localparam int PROG_LEN = 10;
    localparam int PC_W     = $clog2(PROG_LEN);

    localparam logic [PC_W-1:0] PC_LOOP   = 4'd6;
    localparam logic [PC_W-1:0] PC_FINISH = 4'd9;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_LO,
        MS_HI,
        MS_LOG2E,
        MS_LN2,
        MS_RT,
        MS_RECIP
    } mul_sel_t;

    typedef enum logic [1:0] {
        XO_HOLD,
        XO_LOAD,
        XO_ADD_HI
    } xop_t;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_UF,
        JC_MORE
    } jump_t;

    typedef struct packed {
        mul_sel_t        mul_sel;
        xop_t            x_op;
        logic            set_ovf;
        logic            set_big;
        logic            init;
        logic            ld_r;
        logic            ld_v;
        logic            horner;
        logic            last;
        jump_t           jmp;
        logic [PC_W-1:0] target;
    } mat_ctrl_t;

    // Datapath status for conditional jumps
    typedef struct packed {
        logic uf;
        logic more;
    } mat_flags_t;

    localparam mat_ctrl_t CTRL_NOP = '{
        mul_sel: MS_NONE,
        x_op:    XO_HOLD,
        jmp:     JC_NONE,
        default: '0
    };

    // Microcode table: one control word per step
    function automatic mat_ctrl_t prog_word(input logic [PC_W-1:0] pc);
        mat_ctrl_t w;
        w = CTRL_NOP;
        unique case (pc)
            4'd0: w.mul_sel = MS_LO;
            4'd1:
            begin
                w.mul_sel = MS_HI;
                w.x_op    = XO_LOAD;
            end
            4'd2:
            begin
                w.x_op    = XO_ADD_HI;
                w.set_ovf = 1'b1;
            end
            4'd3:
            begin
                w.set_big = 1'b1;
                w.mul_sel = MS_LOG2E;
                w.jmp     = JC_UF;
                w.target  = PC_FINISH;
            end
            4'd4:
            begin
                w.mul_sel = MS_LN2;
                w.init    = 1'b1;
            end
            4'd5: w.ld_r = 1'b1;
            4'd6: w.mul_sel = MS_RT;
            4'd7:
            begin
                w.ld_v    = 1'b1;
                w.mul_sel = MS_RECIP;
            end
            4'd8:
            begin
                w.horner = 1'b1;
                w.jmp    = JC_MORE;
                w.target = PC_LOOP;
            end
            4'd9: w.last = 1'b1;
            default: w = CTRL_NOP;
        endcase
        return w;
    endfunction

    // floor(2^35 / k) for the Horner divisors
    function automatic logic [MUL_B_W-1:0] recip_q35(input logic [K_W-1:0] k);
        logic [MUL_B_W-1:0] m;
        unique case (k)
            4'd1:    m = 36'd34359738368;
            4'd2:    m = 36'd17179869184;
            4'd3:    m = 36'd11453246122;
            4'd4:    m = 36'd8589934592;
            4'd5:    m = 36'd6871947673;
            4'd6:    m = 36'd5726623061;
            4'd7:    m = 36'd4908534052;
            4'd8:    m = 36'd4294967296;
            4'd9:    m = 36'd3817748707;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ----- sv/mat_seq.sv -----
// Microcode sequencer: step counter, table lookup and conditional jumps.
// Depends on mat_pkg.
module mat_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mat_pkg::mat_flags_t flags,
    output mat_pkg::mat_ctrl_t  ctrl,
    output logic                done
);
    import mat_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic            run_reg;
    logic            taken;

    // Current control word, idle word when stopped
    assign ctrl = run_reg ? prog_word(pc_reg) : CTRL_NOP;
    assign done = run_reg && ctrl.last;

    // Jump decode
    always_comb
    begin
        unique case (ctrl.jmp)
            JC_UF:   taken = flags.uf;
            JC_MORE: taken = flags.more;
            default: taken = 1'b0;
        endcase
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= '0;
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            pc_reg  <= '0;
            run_reg <= 1'b1;
        end
        else if (run_reg)
        begin
            pc_reg <= taken ? ctrl.target : pc_reg + 1'b1;
            if (ctrl.last)
                run_reg <= 1'b0;
        end
    end

    a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && !ctrl.last) |=> run_reg)
        else $error("sequencer stopped before its final step");

endmodule

// ----- sv/mat_dp.sv -----
// Exp datapath: shared multiplier, x accumulator, Horner registers and final compare.
// Depends on mat_pkg; driven by control words from mat_seq.
module mat_dp (
    input  logic                                clk,
    input  mat_pkg::mat_ctrl_t                  ctrl,
    input  logic [mat_pkg::ENERGY_WIDTH-1:0]    rise,
    input  logic [mat_pkg::ITEMP_W-1:0]         inv_temp,
    input  logic [mat_pkg::DICE_BITS-1:0]       dice,
    output mat_pkg::mat_flags_t                 flags,
    output logic                                move_ok
);
    import mat_pkg::*;

    logic [MUL_P_W-1:0] mul_reg;
    logic [63:0]        x_reg;
    logic               zero_reg;
    logic [T_W-1:0]     t_reg;
    logic [31:0]        r_reg;
    logic [31:0]        v_reg;
    logic [K_W-1:0]     k_reg;
    logic [SHIFT_W-1:0] n_reg;

    logic [63:0]        rise_ext;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               x_big;
    logic [31:0]        q0;
    logic [35:0]        rem;
    logic               bump;
    logic [T_W-1:0]     t_next;
    logic [T_W-1:0]     prob;
    logic [T_W-1:0]     dice_scaled;

    assign rise_ext = 64'(rise);
    assign x_big    = (x_reg >= X_LIMIT);

    // Operand select for the shared multiplier
    always_comb
    begin
        unique case (ctrl.mul_sel)
            MS_LO:
            begin
                mul_a = MUL_A_W'(rise_ext[31:0]);
                mul_b = MUL_B_W'(inv_temp);
            end
            MS_HI:
            begin
                mul_a = MUL_A_W'(rise_ext[63:32]);
                mul_b = MUL_B_W'(inv_temp);
            end
            MS_LOG2E:
            begin
                mul_a = x_reg[44:8];
                mul_b = LOG2E_Q24;
            end
            MS_LN2:
            begin
                mul_a = MUL_A_W'(mul_reg[55:24]);
                mul_b = LN2_Q32;
            end
            MS_RT:
            begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = MUL_B_W'(r_reg);
            end
            MS_RECIP:
            begin
                mul_a = MUL_A_W'(mul_reg[63:32]);
                mul_b = recip_q35(k_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // One Horner term: t = 1 - ((r*t) >> 32) / k, quotient fixed up by one compare
    always_comb
    begin
        q0     = mul_reg[66:35];
        rem    = 36'(v_reg) - 36'(q0) * 36'(k_reg);
        bump   = (rem >= 36'(k_reg));
        t_next = ONE_Q32 - (T_W'(q0) + T_W'(bump));
    end

    // Final probability and compare against the scaled dice
    assign prob        = t_reg >> n_reg;
    assign dice_scaled = T_W'(dice) << (32 - DICE_BITS);
    assign move_ok     = !zero_reg && (prob > dice_scaled);

    assign flags.uf   = zero_reg | x_big;
    assign flags.more = (k_reg != 4'd1);

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_sel != MS_NONE)
            mul_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

        unique case (ctrl.x_op)
            XO_LOAD:   x_reg <= mul_reg[63:0];
            XO_ADD_HI: x_reg <= x_reg + {mul_reg[31:0], 32'b0};
            default:   x_reg <= x_reg;
        endcase

        // Underflow: high partial product too large, or x past 23
        if (ctrl.set_ovf)
            zero_reg <= (mul_reg[MUL_P_W-1:20] != '0);
        if (ctrl.set_big)
            zero_reg <= zero_reg | x_big;

        if (ctrl.init)
        begin
            t_reg <= ONE_Q32;
            k_reg <= HORNER_TOP;
            n_reg <= mul_reg[61:56];
        end
        if (ctrl.ld_r)
            r_reg <= mul_reg[63:32];
        if (ctrl.ld_v)
            v_reg <= mul_reg[63:32];
        if (ctrl.horner)
        begin
            t_reg <= t_next;
            k_reg <= k_reg - 1'b1;
        end
    end

endmodule

// ----- sv/metropolis_acceptance_test_unit.sv -----
// Rising trial: the microprogram starts on the accepting edge; a trial whose exp underflows
// jumps past the Horner loop; a restart or a trial with no energy rise skips the microprogram.
// The next beat is taken once the unit is idle again. Exp runs as a 34-step microprogram on
// one shared 37x36 multiplier, the nine-term Horner loop at three steps per term.
// Reset (async, active low) loads the config defaults, trial counter 1, done flag clear.
// Top level: handshakes, config registers, trial counter; uses mat_pkg, mat_seq, mat_dp.
module metropolis_acceptance_test_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [mat_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mat_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  mat_pkg::mat_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output mat_pkg::mat_out_t               out_data
);
    import mat_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } state_t;

    state_t                         state_reg;
    logic [ITEMP_W-1:0]             inv_temp_reg;
    logic [ATOMS_W-1:0]             atom_count_reg;
    logic [COUNT_W-1:0]             count_reg;
    logic                           done_reg;
    logic signed [ENERGY_WIDTH-1:0] old_reg;
    logic signed [ENERGY_WIDTH-1:0] new_reg;
    logic [ENERGY_WIDTH-1:0]        rise_reg;
    logic [DICE_BITS-1:0]           dice_reg;
    mat_out_t                       res_reg;
    mat_out_t                       out_data_reg;
    logic                           out_valid_reg;

    logic [COUNT_W-1:0]             count_next;
    logic                           done_next;
    logic                           no_rise;
    logic                           slot_free;
    logic                           seq_start;
    logic                           seq_done;
    logic                           move_ok;
    mat_ctrl_t                      ctrl;
    mat_flags_t                     flags;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    // Saturating trial count and sticky done flag
    assign count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign done_next  = done_reg | (count_next > COUNT_W'(atom_count_reg));
    assign no_rise    = (in_data.new_energy <= in_data.old_energy);
    assign seq_start  = (state_reg == S_IDLE) && in_valid
                        && (in_data.req_type == REQ_TRIAL) && !no_rise;

    mat_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seq_start),
        .flags (flags),
        .ctrl  (ctrl),
        .done  (seq_done)
    );

    mat_dp u_dp (
        .clk      (clk),
        .ctrl     (ctrl),
        .rise     (rise_reg),
        .inv_temp (inv_temp_reg),
        .dice     (dice_reg),
        .flags    (flags),
        .move_ok  (move_ok)
    );

    // Control state, config, counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            inv_temp_reg   <= INV_TEMP_RST;
            atom_count_reg <= ATOM_COUNT_RST;
            count_reg      <= COUNT_W'(1);
            done_reg       <= 1'b0;
            old_reg        <= '0;
            new_reg        <= '0;
            rise_reg       <= '0;
            dice_reg       <= '0;
            res_reg        <= '0;
            out_data_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_INV_TEMP:   inv_temp_reg   <= cfg_data;
                    REG_ATOM_COUNT: atom_count_reg <= cfg_data[ATOMS_W-1:0];
                    default:        inv_temp_reg   <= inv_temp_reg;
                endcase
            end

            // Drain the output beat unless a new one is loaded this edge
            if (out_valid_reg && !out_stall && state_reg != S_HOLD)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_data.req_type == REQ_RESTART)
                        begin
                            count_reg              <= COUNT_W'(1);
                            res_reg.accepted       <= 1'b0;
                            res_reg.current_energy <= '0;
                            res_reg.sweep_done     <= done_reg;
                            state_reg              <= S_HOLD;
                        end
                        else
                        begin
                            count_reg          <= count_next;
                            done_reg           <= done_next;
                            old_reg            <= in_data.old_energy;
                            new_reg            <= in_data.new_energy;
                            rise_reg           <= in_data.new_energy - in_data.old_energy;
                            dice_reg           <= in_data.dice;
                            res_reg.sweep_done <= done_next;
                            if (no_rise)
                            begin
                                res_reg.accepted       <= 1'b1;
                                res_reg.current_energy <= in_data.new_energy;
                                state_reg              <= S_HOLD;
                            end
                            else
                                state_reg <= S_RUN;
                        end
                    end
                end
                S_RUN:
                begin
                    if (seq_done)
                    begin
                        res_reg.accepted       <= move_ok;
                        res_reg.current_energy <= move_ok ? new_reg : old_reg;
                        state_reg              <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (slot_free)
                    begin
                        out_data_reg  <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("sweep done flag dropped");

    a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.req_type == REQ_RESTART) |=> (count_reg == COUNT_W'(1)))
        else $error("restart beat did not reset the trial counter");

    a_seq_done_run: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |-> (state_reg == S_RUN))
        else $error("microprogram finished outside a running trial");

endmodule
